// ----- hw/rtl/qft_pkg.sv -----
// Shared types, constants and the field-character helper for the quoted field tokenizer.
package qft_pkg;

    // Most results one input character may produce; later ones are dropped.
    localparam int MAX_RESULTS = 35;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM  = 3'd0,
        REG_QUOTE  = 3'd1,
        REG_ESCAPE = 3'd2,
        REG_GATHER = 3'd3,
        REG_KEEP   = 3'd4,
        REG_TRIM   = 3'd5
    } cfg_reg_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_EOF  = 2'd1,
        KIND_EOS  = 2'd2
    } kind_t;

    // One queued result.
    typedef struct packed {
        logic       vld;
        kind_t      kind;
        logic [7:0] ch;
    } slot_t;

    // Result of routing one character through the field logic, with updated field flags.
    typedef struct packed {
        slot_t res;
        logic  fo;
        logic  nf;
        logic  sk;
    } path_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic pop;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic plan_any;
        logic last;
    } sts_t;

    // A delimiter outside quotes closes the field; anything else is copied if asked.
    function automatic path_t char_path(input logic iq, input logic [7:0] ch, input logic copy,
                                        input logic [7:0] delim, input logic gather,
                                        input logic fo, input logic nf, input logic sk);
        path_t p;
        p     = '0;
        p.fo  = fo;
        p.nf  = nf;
        p.sk  = sk;
        if (!iq && ch == delim)
        begin
            p.res.vld  = 1'b1;
            p.res.kind = KIND_EOF;
            p.fo       = 1'b0;
            p.nf       = 1'b1;
            p.sk       = gather;
        end
        else
        begin
            if (copy)
            begin
                p.res.vld  = 1'b1;
                p.res.kind = KIND_CHAR;
                p.res.ch   = ch;
            end
            p.nf = 1'b0;
        end
        return p;
    endfunction

endpackage

// ----- hw/rtl/qft_if.sv -----
// Stream interfaces for the character input channel and the result output channel.
interface qft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_final;

    modport source (output valid, output char_in, output is_final, input ready);
    modport sink   (input valid, input char_in, input is_final, output ready);
endinterface

interface qft_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic [1:0] kind;
    logic       escape_overflow;
    logic       run_last;

    modport source (output valid, output char_out, output kind, output escape_overflow,
                    output run_last, input ready);
    modport sink   (input valid, input char_out, input kind, input escape_overflow,
                    input run_last, output ready);
endinterface

// ----- hw/rtl/quoted_field_tokenizer.sv -----
// Top level of the quoted field tokenizer: controller, datapath and channel wiring.
//
// Usage: one character per beat on in_ch, with is_final on the last character of a
// string. Each character yields zero or more result beats on out_ch: field characters
// (kind 0), end of field (kind 1) and end of string (kind 2); run_last marks the final
// beat caused by a character and escape_overflow marks every beat of a step that
// flushes a saturated escape run.
// A character that gives no result leaves the sequencer idle; one that gives results
// holds the input off while the result sequencer issues one beat per cycle, as long as
// out_ch.ready allows, through the single output register; an escape run flush thus
// issues one beat per flushed escape, each loaded from the plan registers in EMIT.
// in_ch.ready is high while the sequencer is idle, including while the last result of
// the previous character still sits unconsumed in the output register.
// When out_ch.ready is low the output beat holds and the sequencer waits.
// Reset sets the registers to delimiter space, quote double quote, escape backslash,
// gathering on, quotes dropped, trailing empty field trimmed, and clears string state.
// Configuration writes on cfg_we / cfg_index / cfg_data take effect at the next edge; the
// user must make them only while the block is idle, unchecked; other indexes are ignored.
module quoted_field_tokenizer #(
    parameter int ESC_MAX = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    qft_in_if.sink                        in_ch,
    qft_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [qft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import qft_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing of accept and result beats.
    qft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Tokenizing logic and output register.
    qft_datapath #(
        .ESC_MAX (ESC_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_char   (in_ch.char_in),
        .in_final  (in_ch.is_final),
        .out_char  (out_ch.char_out),
        .out_kind  (out_ch.kind),
        .out_flag  (out_ch.escape_overflow),
        .out_last  (out_ch.run_last)
    );

endmodule

// ----- hw/rtl/qft_ctrl.sv -----
// Controller: accepts one character, then issues its queued results one beat at a time.
module qft_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output qft_pkg::cmd_t cmd,
    input  qft_pkg::sts_t sts
);
    import qft_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        slot_free  = !out_valid_reg || out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && sts.plan_any)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.pop = slot_free;
                if (slot_free && sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.pop || (out_valid_reg && !out_ready);
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/qft_datapath.sv -----
// Datapath: configuration, string state, per-character result plan and output register.
module qft_datapath #(
    parameter int ESC_MAX = 31
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  qft_pkg::cmd_t                  cmd,
    output qft_pkg::sts_t                  sts,
    input  logic                           cfg_we,
    input  logic [qft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic [7:0]                     in_char,
    input  logic                           in_final,
    output logic [7:0]                     out_char,
    output logic [1:0]                     out_kind,
    output logic                           out_flag,
    output logic                           out_last
);
    import qft_pkg::*;

    localparam int EW = $clog2(ESC_MAX + 1);
    localparam int TW = $clog2(ESC_MAX + MAX_RESULTS + 7);

    // Configuration registers.
    logic [7:0] delim_reg, quote_reg, esc_char_reg;
    logic       gather_reg, keep_reg, trim_reg;

    // String state.
    logic          in_quote_reg, in_quote_next;
    logic          at_start_reg, at_start_next;
    logic          field_open_reg, field_open_next;
    logic          need_field_reg, need_field_next;
    logic          skip_reg, skip_next;
    logic [EW-1:0] esc_cnt_reg, esc_cnt_next;
    logic          esc_over_reg, esc_over_next;
    logic          qpend_reg, qpend_next;

    // Result plan of the accepted character.
    slot_t          a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [EW-1:0]  en_reg, en_next;
    logic           d_reg, d_next, e_reg, e_next;
    logic           flag_reg, flag_next;
    logic [TW-1:0]  tot;
    logic [CNT_W-1:0] rem_reg, rem_load;
    slot_t          head;

    // Output register.
    logic [7:0] out_char_reg;
    kind_t      out_kind_reg;
    logic       out_flag_reg, out_last_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg    <= 8'd32;
            quote_reg    <= 8'd34;
            esc_char_reg <= 8'd92;
            gather_reg   <= 1'b1;
            keep_reg     <= 1'b0;
            trim_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELIM:  delim_reg    <= cfg_data;
                REG_QUOTE:  quote_reg    <= cfg_data;
                REG_ESCAPE: esc_char_reg <= cfg_data;
                REG_GATHER: gather_reg   <= cfg_data[0];
                REG_KEEP:   keep_reg     <= cfg_data[0];
                REG_TRIM:   trim_reg     <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Work out the state update and the ordered results for one character.
    always_comb
    begin : eval_step
        path_t         p;
        logic          done;
        logic          take;
        logic [EW-1:0] n;

        p    = '0;
        done = 1'b0;
        take = 1'b0;
        n    = '0;

        in_quote_next   = in_quote_reg;
        at_start_next   = 1'b0;
        field_open_next = field_open_reg;
        need_field_next = need_field_reg;
        skip_next       = skip_reg;
        esc_cnt_next    = esc_cnt_reg;
        esc_over_next   = esc_over_reg;
        qpend_next      = qpend_reg;

        a_next  = '0;
        b_next  = '0;
        c_next  = '0;
        en_next = '0;
        d_next  = 1'b0;
        e_next  = 1'b0;

        // Raised wherever a saturated escape run is flushed.
        flag_next = 1'b0;

        // A leading quote of a longer string only switches quoting on.
        if (at_start_reg && in_char == quote_reg && !in_final)
        begin
            in_quote_next = 1'b1;
            done          = 1'b1;
        end

        // Resolve a quote that waited to see whether it was doubled.
        if (!done && qpend_next)
        begin
            qpend_next    = 1'b0;
            in_quote_next = 1'b0;
            if (in_char == quote_reg)
            begin
                p    = char_path(1'b0, in_char, 1'b1, delim_reg, gather_reg,
                                 field_open_next, need_field_next, skip_next);
                done = 1'b1;
            end
            else
            begin
                p = char_path(1'b0, quote_reg, keep_reg, delim_reg, gather_reg,
                              field_open_next, need_field_next, skip_next);
            end
            a_next          = p.res;
            field_open_next = p.fo;
            need_field_next = p.nf;
            skip_next       = p.sk;
        end

        // Extend or close an escape run.
        if (!done && esc_cnt_next != '0)
        begin
            done = 1'b1;
            if (in_char == esc_char_reg)
            begin
                if (esc_cnt_next < EW'(ESC_MAX))
                begin
                    esc_cnt_next = esc_cnt_next + 1'b1;
                end
                else
                begin
                    esc_over_next = 1'b1;
                end
            end
            else
            begin
                n             = esc_cnt_next;
                esc_cnt_next  = '0;
                flag_next     = esc_over_next;
                esc_over_next = 1'b0;
                if (in_char == quote_reg)
                begin
                    en_next = n >> 1;
                    if (n[0])
                    begin
                        p    = char_path(in_quote_next, in_char, 1'b1, delim_reg, gather_reg,
                                         field_open_next, need_field_next, skip_next);
                        take = 1'b1;
                    end
                    else if (in_quote_next)
                    begin
                        qpend_next = 1'b1;
                    end
                    else
                    begin
                        in_quote_next = 1'b1;
                        p    = char_path(1'b1, in_char, keep_reg, delim_reg, gather_reg,
                                         field_open_next, need_field_next, skip_next);
                        take = 1'b1;
                    end
                end
                else
                begin
                    en_next = n;
                    p    = char_path(in_quote_next, in_char, 1'b1, delim_reg, gather_reg,
                                     field_open_next, need_field_next, skip_next);
                    take = 1'b1;
                end
            end
        end

        // Open a field unless a gathered delimiter run is being skipped.
        if (!done && !field_open_next)
        begin
            if (skip_next && in_char == delim_reg)
            begin
                done = 1'b1;
            end
            else
            begin
                skip_next       = 1'b0;
                field_open_next = 1'b1;
                need_field_next = 1'b0;
            end
        end

        // Ordinary character handling.
        if (!done)
        begin
            if (in_char == esc_char_reg)
            begin
                esc_cnt_next = EW'(1);
            end
            else if (in_char == quote_reg)
            begin
                if (in_quote_next)
                begin
                    qpend_next = 1'b1;
                end
                else
                begin
                    in_quote_next = 1'b1;
                    p    = char_path(1'b1, in_char, keep_reg, delim_reg, gather_reg,
                                     field_open_next, need_field_next, skip_next);
                    take = 1'b1;
                end
            end
            else
            begin
                p    = char_path(in_quote_next, in_char, 1'b1, delim_reg, gather_reg,
                                 field_open_next, need_field_next, skip_next);
                take = 1'b1;
            end
        end

        if (take)
        begin
            b_next          = p.res;
            field_open_next = p.fo;
            need_field_next = p.nf;
            skip_next       = p.sk;
        end

        // End of string: close pending quote, flush escapes, close the field, mark the end.
        if (in_final)
        begin
            if (qpend_next)
            begin
                p = char_path(1'b0, quote_reg, keep_reg, delim_reg, gather_reg,
                              field_open_next, need_field_next, skip_next);
                c_next          = p.res;
                field_open_next = p.fo;
                need_field_next = p.nf;
            end
            if (esc_cnt_next != '0)
            begin
                en_next   = esc_cnt_next;
                flag_next = flag_next || esc_over_next;
            end
            d_next = field_open_next || (need_field_next && !trim_reg);
            e_next = 1'b1;

            in_quote_next   = 1'b0;
            at_start_next   = 1'b1;
            field_open_next = 1'b0;
            need_field_next = 1'b0;
            skip_next       = 1'b0;
            esc_cnt_next    = '0;
            esc_over_next   = 1'b0;
            qpend_next      = 1'b0;
        end
    end

    // Number of results, capped at the per-step limit.
    always_comb
    begin
        tot = TW'(a_next.vld) + TW'(en_next) + TW'(b_next.vld) + TW'(c_next.vld)
            + TW'(d_next) + TW'(e_next);
        rem_load = (tot > TW'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : tot[CNT_W-1:0];
        sts.plan_any = (tot != '0);
        sts.last     = (rem_reg == CNT_W'(1));
    end

    // Head of the plan in result order.
    always_comb
    begin
        priority if (a_reg.vld)
        begin
            head = a_reg;
        end
        else if (en_reg != '0)
        begin
            head = '{vld: 1'b1, kind: KIND_CHAR, ch: esc_char_reg};
        end
        else if (b_reg.vld)
        begin
            head = b_reg;
        end
        else if (c_reg.vld)
        begin
            head = c_reg;
        end
        else if (d_reg)
        begin
            head = '{vld: 1'b1, kind: KIND_EOF, ch: 8'd0};
        end
        else
        begin
            head = '{vld: 1'b1, kind: KIND_EOS, ch: 8'd0};
        end
    end

    // String state and result count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg   <= 1'b0;
            at_start_reg   <= 1'b1;
            field_open_reg <= 1'b0;
            need_field_reg <= 1'b0;
            skip_reg       <= 1'b0;
            esc_cnt_reg    <= '0;
            esc_over_reg   <= 1'b0;
            qpend_reg      <= 1'b0;
            rem_reg        <= '0;
        end
        else if (cmd.load)
        begin
            in_quote_reg   <= in_quote_next;
            at_start_reg   <= at_start_next;
            field_open_reg <= field_open_next;
            need_field_reg <= need_field_next;
            skip_reg       <= skip_next;
            esc_cnt_reg    <= esc_cnt_next;
            esc_over_reg   <= esc_over_next;
            qpend_reg      <= qpend_next;
            rem_reg        <= rem_load;
        end
        else if (cmd.pop)
        begin
            rem_reg <= rem_reg - 1'b1;
        end
    end

    // Plan slots: loaded per character, retired in order as beats go out.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            en_reg   <= en_next;
            d_reg    <= d_next;
            e_reg    <= e_next;
            flag_reg <= flag_next;
        end
        else if (cmd.pop)
        begin
            priority if (a_reg.vld)
            begin
                a_reg.vld <= 1'b0;
            end
            else if (en_reg != '0)
            begin
                en_reg <= en_reg - 1'b1;
            end
            else if (b_reg.vld)
            begin
                b_reg.vld <= 1'b0;
            end
            else if (c_reg.vld)
            begin
                c_reg.vld <= 1'b0;
            end
            else if (d_reg)
            begin
                d_reg <= 1'b0;
            end
            else
            begin
                e_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_char_reg <= head.ch;
            out_kind_reg <= head.kind;
            out_flag_reg <= flag_reg;
            out_last_reg <= (rem_reg == CNT_W'(1));
        end
    end

    assign out_char = out_char_reg;
    assign out_kind = out_kind_reg;
    assign out_flag = out_flag_reg;
    assign out_last = out_last_reg;

    // A new character is taken only once every result of the previous one is out.
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> rem_reg == '0)
        else $error("character loaded while results still queued");

    // A beat is issued only while results remain.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> rem_reg != '0)
        else $error("result issued from an empty plan");

    // The saturation mark only stands with a full escape count.
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        esc_over_reg |-> esc_cnt_reg == EW'(ESC_MAX))
        else $error("escape overflow without saturated count");

    // The escape counter never passes its limit.
    a_esc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        esc_cnt_reg <= EW'(ESC_MAX))
        else $error("escape count above limit");

    // Loading and issuing never coincide.
    a_load_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.pop))
        else $error("load and pop in the same cycle");

endmodule

// ----- sim/qft_checker.sv -----
// Checker for the quoted field tokenizer: watches both channels, predicts, compares beats.
module qft_checker #(
    parameter int ESC_MAX = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    qft_in_if                             in_ch,
    qft_out_if                            out_ch,
    input  logic                          cfg_we,
    input  logic [qft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output int                            fail_count,
    output int                            backlog
);
    import qft_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
        logic       ovf;
        logic       last;
    } token_beat_t;

    // Register copy.
    logic [7:0] delim_chr, quote_chr, esc_chr;
    logic       gather_on, keep_on, trim_on;

    // Per-string tokenizer state.
    logic in_quote, at_start, field_open, need_field, skipping, quote_pending, esc_over;
    int   esc_run;

    // Overflow flag of the step being predicted, beats of that step, and beats still owed.
    logic        ovf_now;
    token_beat_t step_beats[$];
    token_beat_t beats_due[$];

    function automatic void push_beat(input logic [7:0] ch, input kind_t k);
        token_beat_t b;
        if (step_beats.size() >= MAX_RESULTS)
            return;
        b.ch   = ch;
        b.kind = k;
        b.ovf  = ovf_now;
        b.last = 1'b0;
        step_beats.push_back(b);
    endfunction

    // A saturated run raises the overflow flag for the rest of the step.
    function automatic void flush_escapes(input int n);
        if (esc_over)
        begin
            ovf_now  = 1'b1;
            esc_over = 1'b0;
        end
        repeat (n) push_beat(esc_chr, KIND_CHAR);
    endfunction

    // A delimiter outside quotes ends the field; anything else is copied when asked.
    function automatic void route_char(input logic [7:0] c, input logic copy);
        if (!in_quote && c == delim_chr)
        begin
            push_beat(8'h00, KIND_EOF);
            field_open = 1'b0;
            need_field = 1'b1;
            skipping   = gather_on;
        end
        else
        begin
            if (copy)
                push_beat(c, KIND_CHAR);
            need_field = 1'b0;
        end
    endfunction

    // An unescaped quote opens quoting, or inside quotes waits to see if it is doubled.
    function automatic void quote_toggle(input logic [7:0] c);
        if (in_quote)
            quote_pending = 1'b1;
        else
        begin
            in_quote = 1'b1;
            route_char(c, keep_on);
        end
    endfunction

    function automatic void close_quote();
        quote_pending = 1'b0;
        in_quote      = 1'b0;
        route_char(quote_chr, keep_on);
    endfunction

    function automatic void feed_char(input logic [7:0] c);
        int n;
        if (quote_pending)
        begin
            // Doubled quote gives a literal quote and leaves quote mode.
            if (c == quote_chr)
            begin
                quote_pending = 1'b0;
                in_quote      = 1'b0;
                route_char(c, 1'b1);
                return;
            end
            close_quote();
        end
        if (esc_run > 0)
        begin
            if (c == esc_chr)
            begin
                if (esc_run < ESC_MAX)
                    esc_run++;
                else
                    esc_over = 1'b1;
                return;
            end
            n       = esc_run;
            esc_run = 0;
            // Escapes before a quote follow the even/odd rule.
            if (c == quote_chr)
            begin
                flush_escapes(n / 2);
                if (n % 2 == 1)
                    route_char(c, 1'b1);
                else
                    quote_toggle(c);
            end
            else
            begin
                flush_escapes(n);
                route_char(c, 1'b1);
            end
            return;
        end
        if (!field_open)
        begin
            if (skipping && c == delim_chr)
                return;
            skipping   = 1'b0;
            field_open = 1'b1;
            need_field = 1'b0;
        end
        if (c == esc_chr)
            esc_run = 1;
        else if (c == quote_chr)
            quote_toggle(c);
        else
            route_char(c, 1'b1);
    endfunction

    function automatic void clear_string();
        in_quote      = 1'b0;
        at_start      = 1'b1;
        field_open    = 1'b0;
        need_field    = 1'b0;
        skipping      = 1'b0;
        esc_run       = 0;
        quote_pending = 1'b0;
        esc_over      = 1'b0;
    endfunction

    // Works out every beat one accepted character causes and queues them.
    function automatic void tokenize_char(input logic [7:0] c, input logic fin);
        int n;
        step_beats.delete();
        ovf_now = 1'b0;
        if (at_start)
        begin
            at_start = 1'b0;
            // A leading quote of a longer string only switches quote mode on.
            if (c == quote_chr && !fin)
                in_quote = 1'b1;
            else
                feed_char(c);
        end
        else
            feed_char(c);
        if (fin)
        begin
            if (quote_pending)
                close_quote();
            if (esc_run > 0)
            begin
                n       = esc_run;
                esc_run = 0;
                flush_escapes(n);
            end
            if (field_open)
                push_beat(8'h00, KIND_EOF);
            else if (need_field && !trim_on)
                push_beat(8'h00, KIND_EOF);
            push_beat(8'h00, KIND_EOS);
            clear_string();
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            beats_due.push_back(step_beats[i]);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        case (cfg_reg_t'(idx))
            REG_DELIM:  delim_chr = val;
            REG_QUOTE:  quote_chr = val;
            REG_ESCAPE: esc_chr   = val;
            REG_GATHER: gather_on = val[0];
            REG_KEEP:   keep_on   = val[0];
            REG_TRIM:   trim_on   = val[0];
            default:    ;
        endcase
    endfunction

    function automatic void mismatch(input string name, input int want, input int got);
        fail_count++;
        $error("%s: expected %0d, got %0d", name, want, got);
    endfunction

    // Compares one accepted result beat with the oldest one owed.
    function automatic void check_beat();
        token_beat_t want;
        if (beats_due.size() == 0)
        begin
            fail_count++;
            $error("result beat with nothing expected: char_out %0d kind %0d",
                   out_ch.char_out, out_ch.kind);
            return;
        end
        want = beats_due.pop_front();
        if (out_ch.char_out !== want.ch)
            mismatch("char_out", want.ch, out_ch.char_out);
        if (out_ch.kind !== want.kind)
            mismatch("kind", want.kind, out_ch.kind);
        if (out_ch.escape_overflow !== want.ovf)
            mismatch("escape_overflow", want.ovf, out_ch.escape_overflow);
        if (out_ch.run_last !== want.last)
            mismatch("run_last", want.last, out_ch.run_last);
    endfunction

    // Track configuration, predict on input beats, check on output beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_chr  = 8'd32;
            quote_chr  = 8'd34;
            esc_chr    = 8'd92;
            gather_on  = 1'b1;
            keep_on    = 1'b0;
            trim_on    = 1'b1;
            clear_string();
            beats_due.delete();
            fail_count = 0;
            backlog   <= 0;
        end
        else
        begin
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
            if (in_ch.valid && in_ch.ready)
                tokenize_char(in_ch.char_in, in_ch.is_final);
            if (out_ch.valid && out_ch.ready)
                check_beat();
            backlog <= beats_due.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the quoted field tokenizer testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
    import qft_pkg::*;

    localparam int ESC_MAX        = 31;
    localparam int IDLE_LIMIT     = 2000;
    localparam int RANDOM_ITEMS   = 350;
    localparam int PHASE_ITEMS    = 45;
    localparam int PRESSURE_PHASE = 2;
    localparam int HOLD_CYCLES    = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    int                   fail_count;
    int                   backlog;

    qft_in_if  in_ch ();
    qft_out_if out_ch ();

    quoted_field_tokenizer #(
        .ESC_MAX (ESC_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qft_checker #(
        .ESC_MAX (ESC_MAX)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    // Special characters currently programmed, used to bias the random text.
    logic [7:0] cur_delim = 8'd32;
    logic [7:0] cur_quote = 8'd34;
    logic [7:0] cur_esc   = 8'd92;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int phase_no      = 0;
    int hold_left     = 0;
    logic held        = 1'b0;
    int idle_cycles   = 0;
    int random_items  = 0;

    always #5 clk = ~clk;

    // Receiver: random stalls, plus one long hold-off so the block backs up into its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (phase_no == PRESSURE_PHASE && !held)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            held         <= 1'b1;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: too many cycles without any beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offers one character and waits until it is taken.
    task automatic put_char(input logic [7:0] c, input logic fin);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.char_in  <= c;
        in_ch.is_final <= fin;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], i == s.len() - 1);
    endtask

    // Half special characters, a quarter letters and a quarter arbitrary bytes.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return cur_delim;
        else if (r < 35)
            return cur_quote;
        else if (r < 50)
            return cur_esc;
        else if (r < 75)
            return 8'($urandom_range(97, 122));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // One random string, sometimes with a long escape run that can saturate the counter.
    task automatic send_random_string();
        logic [7:0] txt[$];
        int len;
        len = $urandom_range(1, 10);
        while (txt.size() < len)
        begin
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(2, 40)) txt.push_back(cur_esc);
            else
                txt.push_back(pick_char());
        end
        foreach (txt[i])
            put_char(txt[i], i == txt.size() - 1);
        random_items += txt.size();
    endtask

    // Waits until every owed beat has arrived, then lets the pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (backlog != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Picks the register settings and idling mode of one phase and programs the block.
    task automatic configure(input int p);
        logic [7:0] d, q, e;
        logic g, k, t;
        d = 8'($urandom_range(0, 255));
        q = 8'($urandom_range(0, 255));
        e = 8'($urandom_range(0, 255));
        g = 1'($urandom_range(0, 1));
        k = 1'($urandom_range(0, 1));
        t = 1'($urandom_range(0, 1));
        case (p)
            1: begin d = 8'h00; q = 8'hFF; e = 8'h5C; g = 1'b0; k = 1'b1; t = 1'b0; end
            2: begin d = 8'hFF; q = 8'h00; e = 8'h80; g = 1'b1; k = 1'b0; t = 1'b1; end
            3: q = d;
            4: e = q;
            5: e = d;
            6: begin q = d; e = d; end
            default: ;
        endcase
        write_reg(REG_DELIM, d);
        write_reg(REG_QUOTE, q);
        write_reg(REG_ESCAPE, e);
        write_reg(REG_GATHER, {7'd0, g});
        write_reg(REG_KEEP, {7'd0, k});
        write_reg(REG_TRIM, {7'd0, t});
        cfg_we    <= 1'b0;
        cur_delim  = d;
        cur_quote  = q;
        cur_esc    = e;
        case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 80; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 80; end
            default: begin send_idle_pct = 23; stall_pct <= 23; end
        endcase
        phase_no <= p;
        @(posedge clk);
    endtask

    initial
    begin
        int p;
        int phase_start;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DELIM;
        cfg_data       = 8'h00;
        in_ch.valid    = 1'b0;
        in_ch.char_in  = 8'h00;
        in_ch.is_final = 1'b0;
        out_ch.ready   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings with the reset settings: a lone quote, a leading quote with a
        // delimiter and a doubled quote inside, odd and even escape runs before quotes,
        // an unclosed quote ending in an escape run, a trailing delimiter, byte extremes.
        send_text("\"");
        send_text("\"a b\"\"c\"");
        send_text("\\\\\\\" \\\\\"b\\");
        send_text("a  ");
        put_char(8'h00, 1'b0);
        put_char(8'hFF, 1'b1);
        drain();

        // Random phases, each under its own settings and idling mode.
        p = 1;
        while (random_items < RANDOM_ITEMS)
        begin
            configure(p);
            phase_start = random_items;
            while (random_items - phase_start < PHASE_ITEMS)
                send_random_string();
            drain();
            p++;
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/qft_pkg.sv
hw/rtl/qft_if.sv
hw/rtl/qft_ctrl.sv
hw/rtl/qft_datapath.sv
hw/rtl/quoted_field_tokenizer.sv
sim/qft_checker.sv
sim/testbench.sv
